// ===== sv/latched_limit_interlock_assert.svh =====
// assertion macros for the latched limit interlock
`ifndef LATCHED_LIMIT_INTERLOCK_ASSERT_SVH
`define LATCHED_LIMIT_INTERLOCK_ASSERT_SVH

`ifndef SYNTH
// condition that holds at every edge out of reset
`define LLI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition that implies a consequence in the next cycle
`define LLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LLI_ASSERT(lbl, clk, rstn, prop, msg)
`define LLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== sv/lli_pkg.sv =====
// shared types and constants of the latched limit interlock
`timescale 1ns / 1ps
`default_nettype none

package lli_pkg;

  localparam int NUM_TAGS_DEF = 32;
  localparam int TAG_W        = 5;
  localparam int VALUE_W      = 32;
  localparam int TRIP_TAG_W   = 6;

  localparam logic [TRIP_TAG_W-1:0] TAG_NONE = TRIP_TAG_W'(32);

  localparam logic signed [VALUE_W-1:0] LIM_LOW_OFF  = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] LIM_HIGH_OFF = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef enum logic [1:0] {
    ACT_WR_LOW  = 2'd0,
    ACT_WR_HIGH = 2'd1,
    ACT_EVAL    = 2'd2,
    ACT_CLEAR   = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    CLR_NONE   = 2'd0,
    CLR_ACCEPT = 2'd1,
    CLR_REFUSE = 2'd2
  } clr_status_e;

  // word held between the memory read and the evaluation
  typedef struct packed {
    act_e                      action;
    logic [TAG_W-1:0]          tag;
    logic signed [VALUE_W-1:0] value;
    logic                      fault;
    logic                      last;
    logic                      tag_ok;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
  } limits_t;

  typedef struct packed {
    logic                  tripped;
    logic [TRIP_TAG_W-1:0] trip_tag;
    logic                  inhibit;
    clr_status_e           clear_status;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/lli_req_if.sv =====
// input channel: limit writes and scan samples
`timescale 1ns / 1ps
`default_nettype none

interface lli_req_if;
  import lli_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                action;
  logic [TAG_W-1:0]          tag;
  logic signed [VALUE_W-1:0] value;
  logic                      fault;
  logic                      last;

  modport source (output valid, action, tag, value, fault, last, input ready);
  modport sink   (input valid, action, tag, value, fault, last, output ready);
endinterface

`default_nettype wire

// ===== sv/lli_rsp_if.sv =====
// output channel: interlock status after each word
`timescale 1ns / 1ps
`default_nettype none

interface lli_rsp_if;
  import lli_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  tripped;
  logic [TRIP_TAG_W-1:0] trip_tag;
  logic                  inhibit;
  logic [1:0]            clear_status;

  modport source (output valid, tripped, trip_tag, inhibit, clear_status, input ready);
  modport sink   (input valid, tripped, trip_tag, inhibit, clear_status, output ready);
endinterface

`default_nettype wire

// ===== sv/lli_limit_mem.sv =====
// low and high limit memories with per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none

module lli_limit_mem #(
  parameter int NUM_TAGS = lli_pkg::NUM_TAGS_DEF,
  localparam int AW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               wr_lo_i,
  input  wire logic                               wr_hi_i,
  input  wire logic [AW-1:0]                      wr_addr_i,
  input  wire logic signed [lli_pkg::VALUE_W-1:0] wr_data_i,
  input  wire logic                               rd_en_i,
  input  wire logic [AW-1:0]                      rd_addr_i,
  output lli_pkg::limits_t                        lim_o
);
  import lli_pkg::*;

  logic signed [VALUE_W-1:0] lo_mem [NUM_TAGS];
  logic signed [VALUE_W-1:0] hi_mem [NUM_TAGS];
  logic [NUM_TAGS-1:0]       lo_vld_q;
  logic [NUM_TAGS-1:0]       hi_vld_q;
  limits_t                   lim_q;

  // an entry never written reads as its disabled extreme
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_vld_q <= '0;
      hi_vld_q <= '0;
    end else begin
      if (wr_lo_i) lo_vld_q[wr_addr_i] <= 1'b1;
      if (wr_hi_i) hi_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // storage and registered read port
  always_ff @(posedge clk_i) begin
    if (wr_lo_i) lo_mem[wr_addr_i] <= wr_data_i;
    if (wr_hi_i) hi_mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) begin
      lim_q.lo <= lo_vld_q[rd_addr_i] ? lo_mem[rd_addr_i] : LIM_LOW_OFF;
      lim_q.hi <= hi_vld_q[rd_addr_i] ? hi_mem[rd_addr_i] : LIM_HIGH_OFF;
    end
  end

  assign lim_o = lim_q;

endmodule

`default_nettype wire

// ===== sv/lli_eval.sv =====
// limit compare, scan cause, trip latch and output register
`timescale 1ns / 1ps
`default_nettype none

module lli_eval (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              item_vld_i,
  input  wire lli_pkg::item_t    item_i,
  input  wire lli_pkg::limits_t  lim_i,
  input  wire logic              out_ready_i,
  output logic                   adv_o,
  output logic                   out_valid_o,
  output lli_pkg::result_t       res_o
);
  import lli_pkg::*;

  logic                  trip_q, trip_d;
  logic [TRIP_TAG_W-1:0] ltag_q, ltag_d;
  logic                  inh_q, inh_d;
  logic [TRIP_TAG_W-1:0] cause_q, cause_d;
  logic                  out_valid_q;
  result_t               res_q;
  clr_status_e           status;
  logic                  locked;
  logic                  hit;
  logic [TRIP_TAG_W-1:0] cause_now;
  logic                  upd;

  assign adv_o = !out_valid_q || out_ready_i;
  assign upd   = item_vld_i && adv_o;

  // interlock test and cause search
  assign locked = (lim_i.lo != LIM_LOW_OFF) || (lim_i.hi != LIM_HIGH_OFF);
  assign hit    = item_i.tag_ok && locked &&
                  (item_i.fault || (item_i.value > lim_i.hi) || (item_i.value < lim_i.lo));
  assign cause_now = ((cause_q == TAG_NONE) && hit) ? TRIP_TAG_W'(item_i.tag) : cause_q;

  // scan cause tracking and end-of-scan decisions
  always_comb begin
    trip_d  = trip_q;
    ltag_d  = ltag_q;
    inh_d   = inh_q;
    cause_d = cause_q;
    status  = CLR_NONE;
    case (item_i.action) inside
      ACT_EVAL, ACT_CLEAR: begin
        if (!item_i.last) begin
          cause_d = cause_now;
        end else begin
          cause_d = TAG_NONE;
          if (item_i.action == ACT_EVAL) begin
            if (cause_now != TAG_NONE) begin
              trip_d = 1'b1;
              ltag_d = cause_now;
            end
            inh_d = trip_d;
          end else if (!trip_q) begin
            status = CLR_ACCEPT;
          end else if (cause_now != TAG_NONE) begin
            status = CLR_REFUSE;
          end else begin
            trip_d = 1'b0;
            ltag_d = TAG_NONE;
            status = CLR_ACCEPT;
          end
        end
      end
      default: ;
    endcase
  end

  // latch state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trip_q      <= 1'b0;
      ltag_q      <= TAG_NONE;
      inh_q       <= 1'b0;
      cause_q     <= TAG_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (upd) begin
        trip_q  <= trip_d;
        ltag_q  <= ltag_d;
        inh_q   <= inh_d;
        cause_q <= cause_d;
      end
      if (adv_o) out_valid_q <= item_vld_i;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (upd) begin
      res_q.tripped      <= trip_d;
      res_q.trip_tag     <= ltag_d;
      res_q.inhibit      <= inh_d;
      res_q.clear_status <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== sv/latched_limit_interlock.sv =====
// latched limit interlock: per-tag limit tables, scan evaluation and trip latch
//
// Words enter on req_i (valid/ready). Action 0 and 1 write a tag's low or high
// limit; action 2 and 3 carry one sample of an evaluate or a clear scan, last
// marking the final sample. Every word yields exactly one word on rsp_o with
// the trip latch, the latched tag (32 for none), inhibit and the clear status.
// Throughput is one word per cycle unless rsp_o.ready is held low. The limit
// memory read and the word register load at the accepting edge; the compare
// and latch update then load the output register once it is free.
// Limit writes go to memory at acceptance, so a later sample always sees them.
// Reset clears the trip latch, inhibit and the scan cause, and marks every
// limit entry as unwritten, reading back as its disabled extreme; no clearing
// pass is needed.
// When the receiver holds rsp_o.ready low, the output register and the word
// behind it are held and req_i.ready drops once both are full.
`timescale 1ns / 1ps
`default_nettype none
`include "latched_limit_interlock_assert.svh"

module latched_limit_interlock #(
  parameter int NUM_TAGS = lli_pkg::NUM_TAGS_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lli_req_if.sink    req_i,
  lli_rsp_if.source  rsp_o
);
  import lli_pkg::*;

  localparam int AW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;

  logic                      accept;
  logic                      tag_ok;
  logic [AW-1:0]             addr;
  logic                      is_sample;
  logic                      wr_lo;
  logic                      wr_hi;
  logic signed [VALUE_W-1:0] wr_data;
  logic                      adv;
  logic                      item_vld_q;
  item_t                     item_q;
  limits_t                   lim;
  logic                      out_valid;
  result_t                   res;

  // input handshake and decode
  assign req_i.ready = !item_vld_q || adv;
  assign accept      = req_i.valid && req_i.ready;
  assign tag_ok      = int'(req_i.tag) < NUM_TAGS;
  assign addr        = AW'(req_i.tag);
  assign is_sample   = (req_i.action == ACT_EVAL) || (req_i.action == ACT_CLEAR);
  assign wr_lo       = accept && tag_ok && (req_i.action == ACT_WR_LOW);
  assign wr_hi       = accept && tag_ok && (req_i.action == ACT_WR_HIGH);
  assign wr_data     = !req_i.fault ? req_i.value :
                       ((req_i.action == ACT_WR_LOW) ? LIM_LOW_OFF : LIM_HIGH_OFF);

  lli_limit_mem #(
    .NUM_TAGS (NUM_TAGS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_lo_i   (wr_lo),
    .wr_hi_i   (wr_hi),
    .wr_addr_i (addr),
    .wr_data_i (wr_data),
    .rd_en_i   (accept && is_sample && tag_ok),
    .rd_addr_i (addr),
    .lim_o     (lim)
  );

  // word stage alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (accept) begin
      item_vld_q <= 1'b1;
    end else if (adv) begin
      item_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action <= act_e'(req_i.action);
      item_q.tag    <= req_i.tag;
      item_q.value  <= req_i.value;
      item_q.fault  <= req_i.fault;
      item_q.last   <= req_i.last;
      item_q.tag_ok <= tag_ok;
    end
  end

  lli_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_vld_i  (item_vld_q),
    .item_i      (item_q),
    .lim_i       (lim),
    .out_ready_i (rsp_o.ready),
    .adv_o       (adv),
    .out_valid_o (out_valid),
    .res_o       (res)
  );

  // output channel
  assign rsp_o.valid        = out_valid;
  assign rsp_o.tripped      = res.tripped;
  assign rsp_o.trip_tag     = res.trip_tag;
  assign rsp_o.inhibit      = res.inhibit;
  assign rsp_o.clear_status = res.clear_status;

  // latch and tag agree
  `LLI_ASSERT(a_trip_tag, clk_i, rst_ni,
              !out_valid || (res.tripped == (res.trip_tag != TAG_NONE)),
              "trip latch and latched tag disagree")
  // an accepted clear leaves the latch open
  `LLI_ASSERT(a_clr_ok, clk_i, rst_ni,
              !(out_valid && res.clear_status == CLR_ACCEPT) || !res.tripped,
              "clear accepted while still tripped")
  // a refused clear only when tripped
  `LLI_ASSERT(a_clr_ref, clk_i, rst_ni,
              !(out_valid && res.clear_status == CLR_REFUSE) || res.tripped,
              "clear refused while not tripped")
  // a stalled word stays in place
  `LLI_ASSERT_NEXT(a_hold, clk_i, rst_ni, item_vld_q && !adv,
                   item_vld_q && $stable(item_q), "stalled word lost or changed")

endmodule

`default_nettype wire
